FILE: sv/ssa_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the slab slot allocator. Depends on nothing.
package ssa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SLOTS_MAX  = 64;
    localparam int BLK_W      = 4;
    localparam int SLOT_W     = 6;
    localparam int HANDLE_W   = BLK_W + SLOT_W;
    localparam int CNT_W      = 7;
    localparam int TOTAL_W    = 11;
    localparam int ACT_W      = 5;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_BLOCK = 2'd1;

    // Request function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_BAD_FREE   = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    walk_step;
        logic    act_start;
        logic    chain_wr;
        logic    act_link;
        logic    take_rd;
        logic    take_wr;
        logic    free_rd;
        logic    free_wr;
        logic    respond;
        status_t resp_status;
    } ssa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_found;
        logic walk_end;
        logic can_grow;
        logic chain_last;
        logic free_blk_ok;
        logic free_slot_ok;
    } ssa_stat_t;

endpackage

FILE: sv/ssa_ctrl.sv
// Sequencing state machine of the slab slot allocator.
// Depends on ssa_pkg for the command and status types.
module ssa_ctrl
    import ssa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      func,
    input  ssa_stat_t stat,
    output ssa_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CHAIN,
        S_LINK,
        S_TAKE_RD,
        S_TAKE_WR,
        S_FREE_RD,
        S_FREE_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        cmd        = '0;
        cmd.resp_status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (func == FUNC_FREE) ? S_FREE_RD : S_WALK;
                end
            end
            S_WALK:
            begin
                priority if (stat.walk_found)
                begin
                    cmd.take_rd = 1'b1;
                    state_next  = S_TAKE_WR;
                end
                else if (stat.walk_end)
                begin
                    if (stat.can_grow)
                    begin
                        cmd.act_start = 1'b1;
                        state_next    = S_CHAIN;
                    end
                    else
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = ST_ALLOC_FAIL;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_CHAIN:
            begin
                cmd.chain_wr = 1'b1;
                if (stat.chain_last)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.act_link = 1'b1;
                state_next   = S_TAKE_RD;
            end
            S_TAKE_RD:
            begin
                cmd.take_rd = 1'b1;
                state_next  = S_TAKE_WR;
            end
            S_TAKE_WR:
            begin
                cmd.take_wr = 1'b1;
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            S_FREE_RD:
            begin
                if (stat.free_blk_ok)
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_WR;
                end
                else
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_BAD_FREE;
                    state_next      = S_IDLE;
                end
            end
            S_FREE_WR:
            begin
                cmd.respond = 1'b1;
                if (stat.free_slot_ok)
                begin
                    cmd.free_wr = 1'b1;
                end
                else
                begin
                    cmd.resp_status = ST_BAD_FREE;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/ssa_dp.sv
// Datapath of the slab slot allocator: block table, active-block list,
// slot memory, counters and result registers. Depends on ssa_pkg.
module ssa_dp
    import ssa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [HANDLE_W-1:0]   element_handle,
    input  ssa_cmd_t              cmd,
    output ssa_stat_t             stat,
    output logic                  done,
    output logic [1:0]            status,
    output logic [HANDLE_W-1:0]   granted_handle,
    output logic [TOTAL_W-1:0]    in_use_count,
    output logic [ACT_W-1:0]      active_blocks
);

    // Configuration registers.
    logic                  grow_reg;
    logic [CFG_DATA_W-1:0] spb_reg;

    // Block table; the valid bits and the list head are control state.
    logic [NUM_BLOCKS-1:0] active_reg;
    logic [NUM_BLOCKS-1:0] nvalid_reg;
    logic [NUM_BLOCKS-1:0] pvalid_reg;
    logic [BLK_W-1:0]      next_reg    [NUM_BLOCKS];
    logic [BLK_W-1:0]      prev_reg    [NUM_BLOCKS];
    logic [SLOT_W-1:0]     fhead_reg   [NUM_BLOCKS];
    logic [CNT_W-1:0]      use_reg     [NUM_BLOCKS];
    logic [CNT_W-1:0]      chained_reg [NUM_BLOCKS];
    logic [BLK_W-1:0]      head_reg;
    logic                  head_valid_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [ACT_W-1:0]      active_cnt_reg;

    // Walk and sequencing registers.
    logic [HANDLE_W-1:0]   idx_reg;
    logic [BLK_W-1:0]      cur_reg;
    logic                  have_reg;
    logic [STEP_W-1:0]     steps_reg;
    logic [SLOT_W-1:0]     cnt_reg;

    // Result registers.
    logic                  done_reg;
    status_t               status_reg;
    logic [HANDLE_W-1:0]   granted_reg;

    // Slot memory: each entry holds the in-use flag and the free-list link.
    logic [SLOT_W:0]       slot_mem [NUM_BLOCKS*SLOTS_MAX];
    logic [SLOT_W:0]       rd_data_reg;
    logic                  mem_we;
    logic [HANDLE_W-1:0]   mem_waddr;
    logic [SLOT_W:0]       mem_wdata;
    logic                  mem_re;
    logic [HANDLE_W-1:0]   mem_raddr;

    logic [BLK_W-1:0]      fblk;
    logic [SLOT_W-1:0]     fslot;
    logic [BLK_W-1:0]      idle_idx;
    logic                  idle_any;
    logic [CNT_W-1:0]      eff_slots;
    logic [CNT_W-1:0]      chain_succ;
    logic [SLOT_W-1:0]     chain_link;
    logic                  rd_in_use;
    logic [SLOT_W-1:0]     rd_next;
    logic                  release_now;
    logic [BLK_W-1:0]      rel_nx;
    logic [BLK_W-1:0]      rel_pv;

    assign fblk      = idx_reg[HANDLE_W-1:SLOT_W];
    assign fslot     = idx_reg[SLOT_W-1:0];
    assign rd_in_use = rd_data_reg[SLOT_W];
    assign rd_next   = rd_data_reg[SLOT_W-1:0];
    assign rel_nx    = next_reg[fblk];
    assign rel_pv    = prev_reg[fblk];

    // Slot count clamped to its legal range.
    always_comb
    begin
        priority if (spb_reg < CNT_W'(2))
            eff_slots = CNT_W'(2);
        else if (spb_reg > CNT_W'(SLOTS_MAX))
            eff_slots = CNT_W'(SLOTS_MAX);
        else
            eff_slots = spb_reg;
    end

    // Lowest idle block.
    always_comb
    begin
        idle_idx = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                idle_idx = BLK_W'(i);
            end
        end
    end
    assign idle_any = ~&active_reg;

    // Link written for a slot while a new block is chained.
    assign chain_succ = {1'b0, cnt_reg} + CNT_W'(1);
    assign chain_link = (chain_succ < chained_reg[cur_reg]) ? chain_succ[SLOT_W-1:0] : '0;

    // A block that empties is released if growing and it is not the tail.
    assign release_now = cmd.free_wr && (use_reg[fblk] == CNT_W'(1))
                         && grow_reg && nvalid_reg[fblk];

    // Status toward the controller.
    always_comb
    begin
        stat.walk_found   = have_reg && (steps_reg < STEP_W'(NUM_BLOCKS))
                            && (use_reg[cur_reg] < chained_reg[cur_reg]);
        stat.walk_end     = !have_reg || (steps_reg == STEP_W'(NUM_BLOCKS));
        stat.can_grow     = (grow_reg || !head_valid_reg) && idle_any;
        stat.chain_last   = (cnt_reg == SLOT_W'(SLOTS_MAX - 1));
        stat.free_blk_ok  = active_reg[fblk];
        stat.free_slot_ok = rd_in_use;
    end

    // Slot memory port selection.
    always_comb
    begin
        mem_we    = cmd.chain_wr || cmd.take_wr || cmd.free_wr;
        mem_re    = cmd.take_rd || cmd.free_rd;
        mem_raddr = cmd.take_rd ? {cur_reg, fhead_reg[cur_reg]} : idx_reg;
        mem_waddr = idx_reg;
        mem_wdata = {1'b0, fhead_reg[fblk]};
        priority if (cmd.chain_wr)
        begin
            mem_waddr = {cur_reg, cnt_reg};
            mem_wdata = {1'b0, chain_link};
        end
        else if (cmd.take_wr)
        begin
            mem_wdata = {1'b1, rd_next};
        end
    end

    // Slot memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    // Payload registers of the block table and the sequencer.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= element_handle;
        end
        if (cmd.act_start)
        begin
            chained_reg[idle_idx] <= eff_slots;
            cnt_reg               <= '0;
        end
        if (cmd.chain_wr)
        begin
            cnt_reg <= cnt_reg + SLOT_W'(1);
        end
        if (cmd.act_link)
        begin
            next_reg[cur_reg]  <= head_reg;
            fhead_reg[cur_reg] <= '0;
            use_reg[cur_reg]   <= '0;
            if (head_valid_reg)
            begin
                prev_reg[head_reg] <= cur_reg;
            end
        end
        if (cmd.take_rd)
        begin
            idx_reg <= {cur_reg, fhead_reg[cur_reg]};
        end
        if (cmd.take_wr)
        begin
            fhead_reg[cur_reg] <= rd_next;
            use_reg[cur_reg]   <= use_reg[cur_reg] + CNT_W'(1);
        end
        if (cmd.free_wr)
        begin
            fhead_reg[fblk] <= fslot;
            use_reg[fblk]   <= use_reg[fblk] - CNT_W'(1);
        end
        if (release_now && !(head_valid_reg && head_reg == fblk) && pvalid_reg[fblk])
        begin
            next_reg[rel_pv] <= rel_nx;
            prev_reg[rel_nx] <= rel_pv;
        end
        if (cmd.respond)
        begin
            status_reg  <= cmd.resp_status;
            granted_reg <= cmd.take_wr ? idx_reg : '0;
        end
    end

    // Control state: configuration, valid bits, list head, walk, counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_reg       <= 1'b1;
            spb_reg        <= CFG_DATA_W'(SLOTS_MAX);
            active_reg     <= '0;
            nvalid_reg     <= '0;
            pvalid_reg     <= '0;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            total_reg      <= '0;
            active_cnt_reg <= '0;
            have_reg       <= 1'b0;
            steps_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_GROW_ENABLE)
                begin
                    grow_reg <= cfg_data[0];
                end
                else if (cfg_index == CFG_SLOTS_PER_BLOCK)
                begin
                    spb_reg <= cfg_data;
                end
            end
            if (cmd.load)
            begin
                have_reg  <= head_valid_reg;
                steps_reg <= '0;
            end
            if (cmd.walk_step)
            begin
                have_reg  <= nvalid_reg[cur_reg];
                steps_reg <= steps_reg + STEP_W'(1);
            end
            if (cmd.act_link)
            begin
                active_reg[cur_reg] <= 1'b1;
                pvalid_reg[cur_reg] <= 1'b0;
                nvalid_reg[cur_reg] <= head_valid_reg;
                if (head_valid_reg)
                begin
                    pvalid_reg[head_reg] <= 1'b1;
                end
                head_reg       <= cur_reg;
                head_valid_reg <= 1'b1;
                active_cnt_reg <= active_cnt_reg + ACT_W'(1);
            end
            if (cmd.take_wr)
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
            if (cmd.free_wr)
            begin
                total_reg <= total_reg - TOTAL_W'(1);
            end
            if (release_now)
            begin
                if (head_valid_reg && head_reg == fblk)
                begin
                    head_reg           <= rel_nx;
                    pvalid_reg[rel_nx] <= 1'b0;
                end
                else if (pvalid_reg[fblk])
                begin
                    nvalid_reg[rel_pv] <= 1'b1;
                    pvalid_reg[rel_nx] <= 1'b1;
                end
                active_reg[fblk] <= 1'b0;
                nvalid_reg[fblk] <= 1'b0;
                pvalid_reg[fblk] <= 1'b0;
                active_cnt_reg   <= active_cnt_reg - ACT_W'(1);
            end
        end
    end

    // Walk pointer has no reset: it is loaded before every use.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= head_reg;
        end
        else if (cmd.walk_step)
        begin
            cur_reg <= next_reg[cur_reg];
        end
        else if (cmd.act_start)
        begin
            cur_reg <= idle_idx;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_handle = granted_reg;
    assign in_use_count   = total_reg;
    assign active_blocks  = active_cnt_reg;

    // The active-block count matches the active flags.
    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_cnt_reg) == $countones(active_reg))
        else $error("active block count out of step with active flags");

    // Any active block implies a valid list head.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg != '0) |-> head_valid_reg)
        else $error("active blocks without a list head");

    // A slot popped from a free list must not be in use.
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_wr |-> !rd_in_use)
        else $error("allocated a slot that was already in use");

    // A release only takes a block that has a successor.
    a_release_next: assert property (@(posedge clk) disable iff (!rst_n)
        release_now |-> (active_reg[fblk] && nvalid_reg[fblk]))
        else $error("release of a tail or idle block");

endmodule

FILE: sv/slab_slot_allocator.sv
// Top level of the slab slot allocator: controller plus datapath.
// Depends on ssa_pkg, ssa_ctrl and ssa_dp.
//
// Usage: raise start with func (0 allocate, 1 free) and element_handle
// while busy is low; the request is taken at that edge. Exactly one
// result follows: done is high for a single cycle with status,
// granted_handle, in_use_count and active_blocks. The receiver cannot
// stall; results must be taken in the cycle done is high.
// A free reads its slot and then writes it back; a free into an idle
// block is answered without the read. An allocation walks up to 16 list
// entries, and a failed one ends at the list end; when a new block must
// be activated, all 64 of its slots are chained one memory write per
// cycle, then the block is linked and its first free slot is read.
// busy drops in the cycle done is high, so the next request can follow.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; the
// port is always ready. Write it only while busy is low and no result
// is pending.
// Reset (rst_n low, asynchronous) leaves no block active, zero slots in
// use, growing enabled and 64 slots per block.
module slab_slot_allocator
    import ssa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [HANDLE_W-1:0]   element_handle,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [1:0]            status,
    output logic [HANDLE_W-1:0]   granted_handle,
    output logic [TOTAL_W-1:0]    in_use_count,
    output logic [ACT_W-1:0]      active_blocks
);

    ssa_cmd_t  cmd;
    ssa_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencing state machine.
    ssa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Block table, slot memory and result registers.
    ssa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .element_handle (element_handle),
        .cmd            (cmd),
        .stat           (stat),
        .done           (done),
        .status         (status),
        .granted_handle (granted_handle),
        .in_use_count   (in_use_count),
        .active_blocks  (active_blocks)
    );

endmodule

FILE: tb/tb_slab_slot_allocator.sv
// Self-checking testbench for slab_slot_allocator: a directed table, then random phases
// under several register settings, all checked against an in-bench allocator model.
// Depends on ssa_pkg and the slab_slot_allocator RTL.
module tb_slab_slot_allocator
    import ssa_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct packed {
        status_t              st;
        logic [HANDLE_W-1:0]  handle;
        logic [TOTAL_W-1:0]   in_use;
        logic [ACT_W-1:0]     act;
    } alloc_result_t;

    typedef enum int {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                fn;
        logic [HANDLE_W-1:0] arg;
        logic [CFG_DATA_W-1:0] data;
        bit                  typed;
        alloc_result_t       res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  func;
    logic [HANDLE_W-1:0]   element_handle;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic [1:0]            status;
    logic [HANDLE_W-1:0]   granted_handle;
    logic [TOTAL_W-1:0]    in_use_count;
    logic [ACT_W-1:0]      active_blocks;

    slab_slot_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .element_handle(element_handle), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
        .granted_handle(granted_handle), .in_use_count(in_use_count),
        .active_blocks(active_blocks)
    );

    // Allocator model state.
    bit   blk_act[NUM_BLOCKS];
    int   blk_nxt[NUM_BLOCKS];
    int   blk_prv[NUM_BLOCKS];
    bit   nxt_ok[NUM_BLOCKS];
    bit   prv_ok[NUM_BLOCKS];
    int   head_blk;
    bit   head_ok;
    int   free_head[NUM_BLOCKS];
    int   use_cnt[NUM_BLOCKS];
    int   chain_len[NUM_BLOCKS];
    int   slot_link[NUM_BLOCKS*SLOTS_MAX];
    bit   slot_used[NUM_BLOCKS*SLOTS_MAX];
    int   total_used;
    int   num_active;
    bit   grow_on;
    int   slot_cfg;

    alloc_result_t pending_results[$];
    int            live_handles[$];
    int            errors;
    int            idle_cycles;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic model_reset();
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            blk_act[b] = 0; blk_nxt[b] = 0; blk_prv[b] = 0; nxt_ok[b] = 0; prv_ok[b] = 0;
            free_head[b] = 0; use_cnt[b] = 0; chain_len[b] = 0;
        end
        for (int i = 0; i < NUM_BLOCKS*SLOTS_MAX; i++)
        begin
            slot_link[i] = 0; slot_used[i] = 0;
        end
        head_blk = 0; head_ok = 0; total_used = 0; num_active = 0;
        grow_on = 1; slot_cfg = 64;
    endtask

    // Activate the lowest idle block at the list head; returns -1 when none is idle.
    function automatic int activate_lowest();
        int b;
        int n;
        b = 0;
        while (b < NUM_BLOCKS && blk_act[b]) b++;
        if (b >= NUM_BLOCKS) return -1;
        n = (slot_cfg < 2) ? 2 : (slot_cfg > SLOTS_MAX ? SLOTS_MAX : slot_cfg);
        blk_act[b] = 1; chain_len[b] = n; free_head[b] = 0; use_cnt[b] = 0;
        for (int i = 0; i < SLOTS_MAX; i++)
        begin
            slot_used[b*SLOTS_MAX + i] = 0;
            slot_link[b*SLOTS_MAX + i] = (i + 1 < n) ? i + 1 : 0;
        end
        prv_ok[b] = 0; blk_prv[b] = 0;
        nxt_ok[b] = head_ok; blk_nxt[b] = head_ok ? head_blk : 0;
        if (head_ok)
        begin
            blk_prv[head_blk] = b; prv_ok[head_blk] = 1;
        end
        head_blk = b; head_ok = 1; num_active++;
        return b;
    endfunction

    // Unlink an empty block that has a successor.
    function automatic void release_blk(input int b);
        int nx;
        int pv;
        nx = blk_nxt[b];
        pv = blk_prv[b];
        if (head_ok && head_blk == b)
        begin
            head_blk = nx; prv_ok[nx] = 0; blk_prv[nx] = 0;
        end
        else if (prv_ok[b])
        begin
            blk_nxt[pv] = nx; nxt_ok[pv] = 1; blk_prv[nx] = pv; prv_ok[nx] = 1;
        end
        blk_act[b] = 0; nxt_ok[b] = 0; prv_ok[b] = 0; num_active--;
    endfunction

    // Predict the result of one request and update the model.
    function automatic alloc_result_t predict_request(input logic fn, input logic [9:0] h);
        alloc_result_t r;
        int b;
        int s;
        int idx;
        int steps;
        bit have;
        bit found;
        r.st = ST_OK;
        r.handle = '0;
        if (fn == FUNC_ALLOC)
        begin
            b = head_blk; have = head_ok; steps = 0; found = 0;
            while (have && steps < NUM_BLOCKS && !found)
            begin
                if (use_cnt[b] < chain_len[b]) found = 1;
                else
                begin
                    have = nxt_ok[b]; b = blk_nxt[b]; steps++;
                end
            end
            if (!found && (grow_on || !head_ok))
            begin
                b = activate_lowest();
                found = (b >= 0);
            end
            if (found)
            begin
                s = free_head[b] % SLOTS_MAX;
                idx = b*SLOTS_MAX + s;
                slot_used[idx] = 1;
                free_head[b] = slot_link[idx];
                use_cnt[b]++;
                total_used++;
                r.handle = HANDLE_W'(idx);
                live_handles.push_back(idx);
            end
            else r.st = ST_ALLOC_FAIL;
        end
        else
        begin
            b = h / SLOTS_MAX;
            s = h % SLOTS_MAX;
            idx = b*SLOTS_MAX + s;
            if (!blk_act[b] || !slot_used[idx]) r.st = ST_BAD_FREE;
            else
            begin
                slot_link[idx] = free_head[b];
                free_head[b] = s;
                slot_used[idx] = 0;
                use_cnt[b]--;
                total_used--;
                foreach (live_handles[i])
                    if (live_handles[i] == idx)
                    begin
                        live_handles.delete(i);
                        break;
                    end
                if (use_cnt[b] == 0 && grow_on && nxt_ok[b]) release_blk(b);
            end
        end
        r.in_use = TOTAL_W'(total_used);
        r.act = ACT_W'(num_active);
        return r;
    endfunction

    // Send one request and wait for it to be taken.
    task automatic send_request(input logic fn, input logic [9:0] h, input bit typed,
                                input alloc_result_t want);
        alloc_result_t r;
        start <= 1'b1;
        func <= fn;
        element_handle <= h;
        do @(posedge clk); while (busy);
        r = predict_request(fn, h);
        if (typed && r != want)
            report_mismatch($sformatf("typed expectation disagrees for func %0d handle %0d",
                                      fn, h));
        pending_results.push_back(r);
    endtask

    task automatic drop_start();
        start <= 1'b0;
    endtask

    // Wait until every expected result has come, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GROW_ENABLE) grow_on = d[0];
        else if (idx == CFG_SLOTS_PER_BLOCK) slot_cfg = d;
    endtask

    // Random request: mostly allocs and frees of live handles, some noise.
    task automatic random_request(input bit gaps);
        int pick;
        logic fn;
        logic [9:0] h;
        alloc_result_t none;
        none = '{ST_OK, '0, '0, '0};
        pick = $urandom_range(99);
        if (gaps && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        if (live_handles.size() == 0 || pick < 50)
        begin
            fn = FUNC_ALLOC; h = HANDLE_W'($urandom);
        end
        else if (pick < 90)
        begin
            fn = FUNC_FREE;
            h = HANDLE_W'(live_handles[$urandom_range(live_handles.size() - 1)]);
        end
        else
        begin
            fn = FUNC_FREE; h = HANDLE_W'($urandom);
        end
        send_request(fn, h, 1'b0, none);
    endtask

    // Result checker: every done pulse is compared with the oldest expectation.
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request waiting");
            else
            begin
                e = pending_results.pop_front();
                if (status != e.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
                if (granted_handle != e.handle)
                    report_mismatch($sformatf("granted_handle %0d, expected %0d",
                                              granted_handle, e.handle));
                if (in_use_count != e.in_use)
                    report_mismatch($sformatf("in_use_count %0d, expected %0d",
                                              in_use_count, e.in_use));
                if (active_blocks != e.act)
                    report_mismatch($sformatf("active_blocks %0d, expected %0d",
                                              active_blocks, e.act));
            end
        end
    end

    // Watchdog on cycles in which nothing is accepted.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    stim_row_t directed[$];

    initial begin
        int phase_slots[8];
        bit phase_grow[8];
        rst_n = 1'b0;
        start = 1'b0;
        func = 1'b0;
        element_handle = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        model_reset();

        // Directed table: reset values, double free, idle-block free, clamped settings.
        directed = '{
            '{ROW_REQ, FUNC_ALLOC, 10'd0,    7'd0,   1, '{ST_OK, 10'd0, 11'd1, 5'd1}},
            '{ROW_REQ, FUNC_FREE,  10'd0,    7'd0,   1, '{ST_OK, 10'd0, 11'd0, 5'd1}},
            '{ROW_REQ, FUNC_FREE,  10'd0,    7'd0,   1, '{ST_BAD_FREE, 10'd0, 11'd0, 5'd1}},
            '{ROW_REQ, FUNC_FREE,  10'd1023, 7'd0,   1, '{ST_BAD_FREE, 10'd0, 11'd0, 5'd1}},
            '{ROW_REQ, FUNC_ALLOC, 10'd1023, 7'd0,   1, '{ST_OK, 10'd0, 11'd1, 5'd1}},
            '{ROW_REQ, FUNC_ALLOC, 10'd0,    7'd0,   0, '{ST_OK, 10'd0, 11'd0, 5'd0}},
            '{ROW_REQ, FUNC_FREE,  10'd1,    7'd0,   0, '{ST_OK, 10'd0, 11'd0, 5'd0}},
            '{ROW_CFG, 1'b0, 10'(CFG_SLOTS_PER_BLOCK), 7'd0,   0, '{ST_OK, 0, 0, 0}},
            '{ROW_CFG, 1'b0, 10'(CFG_GROW_ENABLE),     7'h7E,  0, '{ST_OK, 0, 0, 0}},
            '{ROW_CFG, 1'b0, 10'd2,                    7'h7F,  0, '{ST_OK, 0, 0, 0}},
            '{ROW_CFG, 1'b0, 10'd3,                    7'h55,  0, '{ST_OK, 0, 0, 0}},
            '{ROW_REQ, FUNC_ALLOC, 10'd0,    7'd0,   0, '{ST_OK, 10'd0, 11'd0, 5'd0}},
            '{ROW_REQ, FUNC_FREE,  10'd64,   7'd0,   0, '{ST_OK, 10'd0, 11'd0, 5'd0}},
            '{ROW_CFG, 1'b0, 10'(CFG_SLOTS_PER_BLOCK), 7'h7F,  0, '{ST_OK, 0, 0, 0}},
            '{ROW_CFG, 1'b0, 10'(CFG_GROW_ENABLE),     7'h01,  0, '{ST_OK, 0, 0, 0}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].arg[CFG_IDX_W-1:0], directed[i].data);
            else
                send_request(directed[i].fn, directed[i].arg, directed[i].typed,
                             directed[i].res);
        end

        // Random phases over several settings, extremes included.
        phase_slots = '{2, 64, 0, 3, 127, 1, 17, 64};
        phase_grow  = '{1, 0, 1, 0, 1, 1, 0, 1};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_GROW_ENABLE, {6'($urandom), phase_grow[p]});
            write_reg(CFG_SLOTS_PER_BLOCK, CFG_DATA_W'(phase_slots[p]));
            for (int n = 0; n < 115; n++)
                random_request(p != 7);
        end
        drop_start();

        // Final drain and verdict.
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
